// ===== sv/sm3_hash_core_top_macros.svh =====
// Assertion macros for the SM3 hash core
`ifndef SM3_HASH_CORE_TOP_MACROS_SVH
`define SM3_HASH_CORE_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define SM3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset
`define SM3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared constants, types and round functions of the SM3 hash core.
// ----------------------------------------------------------------------------
package sm3_pkg;
  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds  = 64;

  localparam logic [31:0] Iv0 = 32'h7380166f;
  localparam logic [31:0] Iv1 = 32'h4914b2b9;
  localparam logic [31:0] Iv2 = 32'h172442d7;
  localparam logic [31:0] Iv3 = 32'hda8a0600;
  localparam logic [31:0] Iv4 = 32'ha96f30bc;
  localparam logic [31:0] Iv5 = 32'h163138aa;
  localparam logic [31:0] Iv6 = 32'he38dee4d;
  localparam logic [31:0] Iv7 = 32'hb0fb0e4e;
  localparam logic [31:0] TjLow  = 32'h79cc4519;
  localparam logic [31:0] TjHigh = 32'h7a879d8a;
  localparam logic [31:0] PadWord = 32'h80000000;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;      // write word into buffer at position
    logic [31:0] word;
    logic       start;     // begin compression of the buffer
    logic       step;      // run one round
    logic [5:0] round;
    logic       fold;      // xor working state into chaining value
    logic       init;      // restore initial value
    logic       shift_out; // rotate chaining value for output
  } sm3_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage

// ===== sv/sm3_datapath.sv =====
// ----------------------------------------------------------------------------
// sm3_datapath
// Block buffer, rolling message schedule, round registers and chaining value.
// ----------------------------------------------------------------------------
module sm3_datapath import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sm3_cmd_t    cmd,
  input  logic [3:0]  pos,
  output logic [31:0] cv_head
);
  logic [31:0] buf_r [BlkWords];
  logic [31:0] w_r [BlkWords];
  logic [31:0] w_nxt;
  logic [31:0] r_r [8];
  logic [31:0] cv_r [8];
  logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2;
  logic        lo;

  // Next schedule word from the 16-word window
  assign w_nxt = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15))
                 ^ rotl(w_r[3], 5'd7) ^ w_r[10];

  // Round function
  always_comb begin
    lo  = (cmd.round < 6'd16);
    tj  = lo ? TjLow : TjHigh;
    a12 = rotl(r_r[0], 5'd12);
    ss1 = rotl(a12 + r_r[4] + rotl(tj, cmd.round[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    ff  = lo ? (r_r[0] ^ r_r[1] ^ r_r[2])
             : ((r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]));
    gg  = lo ? (r_r[4] ^ r_r[5] ^ r_r[6]) : ((r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]));
    tt1 = ff + r_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + r_r[7] + ss1 + w_r[0];
  end

  // Block buffer write
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_r[pos] <= cmd.word;
    end
  end

  // Schedule window and working state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      // The final word of the block arrives with start; take it directly
      for (int i = 0; i < BlkWords - 1; i++) w_r[i] <= buf_r[i];
      w_r[BlkWords-1] <= cmd.word;
      for (int i = 0; i < 8; i++) r_r[i] <= cv_r[i];
    end else if (cmd.step) begin
      for (int i = 0; i < BlkWords - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BlkWords-1] <= w_nxt;
      r_r[0] <= tt1;
      r_r[1] <= r_r[0];
      r_r[2] <= rotl(r_r[1], 5'd9);
      r_r[3] <= r_r[2];
      r_r[4] <= perm0(tt2);
      r_r[5] <= r_r[4];
      r_r[6] <= rotl(r_r[5], 5'd19);
      r_r[7] <= r_r[6];
    end
  end

  // Chaining value: reset, fold, output rotation
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      cv_r[0] <= Iv0; cv_r[1] <= Iv1; cv_r[2] <= Iv2; cv_r[3] <= Iv3;
      cv_r[4] <= Iv4; cv_r[5] <= Iv5; cv_r[6] <= Iv6; cv_r[7] <= Iv7;
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ r_r[i];
    end else if (cmd.shift_out) begin
      for (int i = 0; i < 7; i++) cv_r[i] <= cv_r[i+1];
      cv_r[7] <= cv_r[0];
    end
  end

  assign cv_head = cv_r[0];
endmodule

// ===== sv/sm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: word intake, padding, round count and digest output.
// ----------------------------------------------------------------------------
module sm3_ctrl import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_digest_last,
  output sm3_cmd_t    cmd,
  output logic [3:0]  pos
);
  `include "sm3_hash_core_top_macros.svh"

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StComp = 3'd1;
  localparam logic [2:0] StFold = 3'd2;
  localparam logic [2:0] StPad  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [63:0] len_r, len_nxt;
  logic        fin_r, fin_nxt;     // message ended, padding in progress
  logic        extra_r, extra_nxt; // 0x80 word still owed after full last word
  logic        spill_r, spill_nxt; // pad marker too late for length in this block
  logic        lenw_r, lenw_nxt;   // length words written into the buffer
  logic [2:0]  ocnt_r, ocnt_nxt;
  logic        acc, outacc;
  logic [2:0]  vb;
  logic [31:0] keep, padw;

  assign acc    = in_valid && !in_stall;
  assign outacc = out_valid && !out_stall;
  assign in_stall  = (state_r != StIdle);
  assign out_valid = (state_r == StOut);
  assign out_digest_last = (ocnt_r == 3'd7);
  assign pos = pos_r;

  // Last-word masking and pad marker
  always_comb begin
    vb = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
    case (vb)
      3'd0:    begin keep = 32'h0;        padw = 32'h80000000; end
      3'd1:    begin keep = 32'hff000000; padw = 32'h00800000; end
      3'd2:    begin keep = 32'hffff0000; padw = 32'h00008000; end
      3'd3:    begin keep = 32'hffffff00; padw = 32'h00000080; end
      default: begin keep = 32'hffffffff; padw = 32'h0;        end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r; pos_nxt = pos_r; rnd_nxt = rnd_r; len_nxt = len_r;
    fin_nxt = fin_r; extra_nxt = extra_r; ocnt_nxt = ocnt_r;
    spill_nxt = spill_r; lenw_nxt = lenw_r;
    cmd = '0;
    cmd.round = rnd_r;
    case (state_r)
      StIdle: begin
        if (acc) begin
          cmd.load = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (!in_last_word) begin
            cmd.word = in_message_word;
            len_nxt = len_r + 64'd32;
          end else begin
            cmd.word = (in_message_word & keep) | padw;
            len_nxt = len_r + {58'd0, vb, 3'd0};
            fin_nxt = 1'b1;
            extra_nxt = (vb == 3'd4);
            // Marker at entry 14 or 15 pushes the length into a second block
            spill_nxt = (vb == 3'd4) ? (pos_r == 4'd13 || pos_r == 4'd14)
                                     : (pos_r == 4'd14);
          end
          if (pos_r == 4'd15) begin
            state_nxt = StComp; cmd.start = 1'b1; rnd_nxt = '0;
          end else if (in_last_word) begin
            state_nxt = StPad;
          end
        end
      end
      StPad: begin
        cmd.load = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (extra_r) begin
          cmd.word = PadWord; extra_nxt = 1'b0;
        end else if (spill_r) begin
          cmd.word = '0;
        end else if (pos_r == 4'd14) begin
          cmd.word = len_r[63:32];
        end else if (pos_r == 4'd15) begin
          cmd.word = len_r[31:0];
          lenw_nxt = 1'b1;
        end else begin
          cmd.word = '0;
        end
        if (pos_r == 4'd15) begin
          state_nxt = StComp; cmd.start = 1'b1; rnd_nxt = '0;
          spill_nxt = 1'b0;
        end
      end
      StComp: begin
        cmd.step = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(Rounds - 1)) state_nxt = StFold;
      end
      StFold: begin
        cmd.fold = 1'b1;
        if (!fin_r) state_nxt = StIdle;
        else if (!lenw_r) state_nxt = StPad;
        else begin state_nxt = StOut; ocnt_nxt = '0; end
      end
      StOut: begin
        if (outacc) begin
          cmd.shift_out = 1'b1;
          ocnt_nxt = ocnt_r + 3'd1;
          if (ocnt_r == 3'd7) begin
            cmd.init = 1'b1; state_nxt = StIdle;
            len_nxt = '0; fin_nxt = 1'b0; pos_nxt = '0; lenw_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle; pos_r <= '0; rnd_r <= '0; len_r <= '0;
      fin_r <= 1'b0; extra_r <= 1'b0; ocnt_r <= '0;
      spill_r <= 1'b0; lenw_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pos_r <= pos_nxt; rnd_r <= rnd_nxt; len_r <= len_nxt;
      fin_r <= fin_nxt; extra_r <= extra_nxt; ocnt_r <= ocnt_nxt;
      spill_r <= spill_nxt; lenw_r <= lenw_nxt;
    end
  end

  `SM3_ASSERT_IMP(a_out_only_fin, out_valid, fin_r && pos_r == 4'd0, "output without padded message")
  `SM3_ASSERT_NXT(a_fold_after_rounds, state_r == StComp && rnd_r == 6'd63, state_r == StFold, "fold missed")
  `SM3_ASSERT_IMP(a_no_in_busy, state_r != StIdle, !acc, "input taken while busy")
endmodule

// ===== sv/sm3_hash_core_top.sv =====
// SM3 hash core: one 64-round compression per 16-word block, one round per cycle.
// Input words are taken while idle; after a full block, input stalls through the rounds and fold.
// Last word: padding words fill out the block (and one more block if needed), then 8 digest beats.
// Synchronous active-low reset restores the initial value and clears the length.
// ----------------------------------------------------------------------------
// sm3_hash_core_top
// Top level joining the SM3 controller and datapath.
// ----------------------------------------------------------------------------
module sm3_hash_core_top import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);
  sm3_cmd_t   cmd;
  logic [3:0] pos;

  sm3_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_message_word, .in_valid_bytes,
    .in_last_word, .out_valid, .out_stall, .out_digest_last, .cmd, .pos
  );

  sm3_datapath u_dp (
    .clk, .rst_n, .cmd, .pos, .cv_head(out_digest_word)
  );
endmodule
